FILE: rtl/assert_macros.svh
// Assertion macros for the RTL of the UTF-8 byte stream decoder.
// Plain defines only; the decoder top level includes this file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define U8D_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("u8d: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define U8D_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("u8d: next-cycle check failed");

`endif

FILE: rtl/u8d_pkg.sv
// Package for the UTF-8 byte stream decoder: widths, byte class masks,
// pending counts and the structs passed between the decoder's modules.
`default_nettype none

package u8d_pkg;

   localparam int BYTE_W    = 8;
   localparam int CP_W      = 21;
   localparam int PEND_W    = 2;
   localparam int CONT_BITS = 6;

   typedef logic [BYTE_W-1:0] byte_type;
   typedef logic [CP_W-1:0]   cp_type;
   typedef logic [PEND_W-1:0] pend_type;

   // byte classes
   localparam byte_type ZERO_BYTE  = 8'h00;
   localparam byte_type ASCII_MASK = 8'h80;
   localparam byte_type LEAD2_MASK = 8'hE0;
   localparam byte_type LEAD2_CODE = 8'hC0;
   localparam byte_type LEAD3_MASK = 8'hF0;
   localparam byte_type LEAD3_CODE = 8'hE0;
   localparam byte_type LEAD4_MASK = 8'hF8;
   localparam byte_type LEAD4_CODE = 8'hF0;
   localparam byte_type LEAD2_PAY  = 8'h1F;
   localparam byte_type LEAD3_PAY  = 8'h0F;
   localparam byte_type LEAD4_PAY  = 8'h07;
   localparam byte_type CONT_PAY   = 8'h3F;

   // continuation bytes still owed
   localparam pend_type PEND_IDLE  = 2'd0;
   localparam pend_type PEND_ONE   = 2'd1;
   localparam pend_type PEND_TWO   = 2'd2;
   localparam pend_type PEND_THREE = 2'd3;

   typedef struct packed {
      logic     valid;
      byte_type byte_in;
   } stage_type;

   typedef struct packed {
      logic   valid;
      cp_type code_point;
      logic   end_marker;
   } result_type;

   typedef struct packed {
      pend_type pend;
      cp_type   part;
   } dec_state_type;

endpackage

`default_nettype wire

FILE: rtl/u8d_channel_if.sv
// Valid/ready channel interfaces for the decoder's byte input and code point
// output. Depends on u8d_pkg.
`default_nettype none

interface u8d_req_if
   import u8d_pkg::*;
   ();
   logic     valid;
   logic     ready;
   byte_type byte_in;

   modport source (output valid, output byte_in, input ready);
   modport sink   (input valid, input byte_in, output ready);
endinterface

interface u8d_rsp_if
   import u8d_pkg::*;
   ();
   logic   valid;
   logic   ready;
   cp_type code_point;
   logic   end_marker;

   modport source (output valid, output code_point, output end_marker, input ready);
   modport sink   (input valid, input code_point, input end_marker, output ready);
endinterface

`default_nettype wire

FILE: rtl/u8d_in_stage.sv
// Input register of the decoder: captures one byte item from the request
// channel. Depends on u8d_pkg and u8d_req_if.
`default_nettype none

module u8d_in_stage
   import u8d_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   u8d_req_if.sink   req_chan,
   input  wire logic advance,
   output stage_type stg
);

   logic     valid_ff, valid_in;
   byte_type byte_ff, byte_in;
   logic     take;

   assign req_chan.ready = !valid_ff || advance;
   assign take           = req_chan.valid && req_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      if (take) begin
         valid_in = 1'b1;
         byte_in  = req_chan.byte_in;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      byte_ff <= byte_in;
   end

   assign stg.valid   = valid_ff;
   assign stg.byte_in = byte_ff;

endmodule

`default_nettype wire

FILE: rtl/u8d_decode.sv
// Decode step: sequence state registers and the per-byte combinational
// decode into zero or one result. Depends on u8d_pkg.
`default_nettype none

module u8d_decode
   import u8d_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire stage_type stg,
   input  wire logic     advance,
   output result_type    res,
   output dec_state_type dst
);

   pend_type pend_ff, pend_in, pend_dec;
   cp_type   part_ff, part_in, part_cat;
   byte_type b, cont_masked;

   assign b           = stg.byte_in;
   assign cont_masked = b & CONT_PAY;
   assign part_cat    = {part_ff[CP_W-CONT_BITS-1:0], cont_masked[CONT_BITS-1:0]};
   assign pend_dec    = pend_ff - PEND_ONE;

   always_comb begin
      pend_in        = pend_ff;
      part_in        = part_ff;
      res.valid      = 1'b0;
      res.code_point = '0;
      res.end_marker = 1'b0;
      if (b == ZERO_BYTE) begin
         // end of string: drop any partial sequence
         pend_in        = PEND_IDLE;
         part_in        = '0;
         res.valid      = 1'b1;
         res.end_marker = 1'b1;
      end else if (pend_ff != PEND_IDLE) begin
         // any nonzero byte counts as a continuation
         pend_in = pend_dec;
         part_in = part_cat;
         if (pend_dec == PEND_IDLE) begin
            part_in        = '0;
            res.valid      = 1'b1;
            res.code_point = part_cat;
         end
      end else if ((b & ASCII_MASK) == ZERO_BYTE) begin
         res.valid      = 1'b1;
         res.code_point = CP_W'(b);
      end else if ((b & LEAD2_MASK) == LEAD2_CODE) begin
         pend_in = PEND_ONE;
         part_in = CP_W'(b & LEAD2_PAY);
      end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
         pend_in = PEND_TWO;
         part_in = CP_W'(b & LEAD3_PAY);
      end else if ((b & LEAD4_MASK) == LEAD4_CODE) begin
         pend_in = PEND_THREE;
         part_in = CP_W'(b & LEAD4_PAY);
      end
      // stray continuation and 11111xxx leads fall through: skipped
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= PEND_IDLE;
         part_ff <= '0;
      end else if (advance) begin
         pend_ff <= pend_in;
         part_ff <= part_in;
      end
   end

   assign dst.pend = pend_ff;
   assign dst.part = part_ff;

endmodule

`default_nettype wire

FILE: rtl/u8d_out_stage.sv
// Result register of the decoder: holds one code point item for the
// response channel. Depends on u8d_pkg and u8d_rsp_if.
`default_nettype none

module u8d_out_stage
   import u8d_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire result_type res,
   input  wire logic  load,
   u8d_rsp_if.source  rsp_chan,
   output logic       space
);

   logic   valid_ff, valid_in;
   cp_type cp_ff, cp_in;
   logic   end_ff, end_in;

   assign space = !valid_ff || rsp_chan.ready;

   always_comb begin
      valid_in = valid_ff && !rsp_chan.ready;
      cp_in    = cp_ff;
      end_in   = end_ff;
      if (load) begin
         valid_in = res.valid;
         cp_in    = res.code_point;
         end_in   = res.end_marker;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      cp_ff  <= cp_in;
      end_ff <= end_in;
   end

   assign rsp_chan.valid      = valid_ff;
   assign rsp_chan.code_point = cp_ff;
   assign rsp_chan.end_marker = end_ff;

endmodule

`default_nettype wire

FILE: rtl/utf8_byte_stream_decoder.sv
// UTF-8 byte stream decoder, top level. Takes one raw byte per item on req_chan
// and returns code points on rsp_chan: an ASCII byte yields a result at once,
// a 2/3/4-byte sequence yields one result on its last byte, and a zero byte
// yields an end marker (code point 0) after dropping any partial sequence.
// Decoding is lenient: continuation bytes are not checked, overlong forms and
// surrogates pass, stray continuations and 11111xxx leads give no result.
// Rate: one byte per clock sustained while rsp_chan.ready stays high; a result
// moves from the input register through one decode step into the result
// register before it shows on rsp_chan. req_chan.ready follows rsp_chan.ready
// combinationally when both registers are full. Depends on u8d_pkg, the channel
// interfaces and the three stage modules.
`default_nettype none
`include "assert_macros.svh"

module utf8_byte_stream_decoder
   import u8d_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   u8d_req_if.sink   req_chan,
   u8d_rsp_if.source rsp_chan
);

   stage_type     stg;
   result_type    res;
   dec_state_type dst;
   logic          space;
   logic          advance;
   logic          end_item;
   logic          part_ok;
   logic          zero_taken;
   logic          state_clear;
   logic          stall_in;

   // The byte in the input register moves through decode whenever the
   // result register is empty or being drained this cycle.
   assign advance = stg.valid && space;

   u8d_in_stage u_in (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .advance  (advance),
      .stg      (stg)
   );

   // Decoder state only changes on advance, so a stalled byte is decoded
   // against the same state until it moves on.
   u8d_decode u_dec (
      .clock   (clock),
      .reset   (reset),
      .stg     (stg),
      .advance (advance),
      .res     (res),
      .dst     (dst)
   );

   u8d_out_stage u_out (
      .clock    (clock),
      .reset    (reset),
      .res      (res),
      .load     (advance),
      .rsp_chan (rsp_chan),
      .space    (space)
   );

   // terms for the checks below
   assign end_item    = rsp_chan.valid && rsp_chan.end_marker;
   assign part_ok     = (dst.pend == PEND_IDLE  && dst.part == '0) ||
                        (dst.pend == PEND_ONE   && dst.part[20:15] == '0) ||
                        (dst.pend == PEND_TWO   && dst.part[20:9] == '0) ||
                        (dst.pend == PEND_THREE && dst.part[20:3] == '0);
   assign zero_taken  = advance && stg.byte_in == ZERO_BYTE;
   assign state_clear = dst.pend == PEND_IDLE && dst.part == '0;
   assign stall_in    = stg.valid && !advance;

   // End marker items never carry a code point.
   `U8D_ASSERT_IMP(a_end_zero_cp, clock, reset, end_item, rsp_chan.code_point == '0)

   // Partial value never holds more bits than the bytes seen so far allow.
   `U8D_ASSERT_IMP(a_part_bound, clock, reset, 1'b1, part_ok)

   // A zero byte that is decoded leaves the state idle and clear.
   `U8D_ASSERT_NXT(a_zero_clears, clock, reset, zero_taken, state_clear)

   // A byte that cannot move on stays in the input register.
   `U8D_ASSERT_NXT(a_in_hold, clock, reset, stall_in, stg.valid && $stable(stg.byte_in))

endmodule

`default_nettype wire

FILE: sim/tb_utf8_byte_stream_decoder.sv
// Self-checking testbench for utf8_byte_stream_decoder: random and directed
// byte streams, predicted code points checked in order on the result channel.
// Depends on u8d_pkg, the channel interfaces in u8d_channel_if.sv and the RTL.
`timescale 1ns / 1ps

module tb_utf8_byte_stream_decoder
   import u8d_pkg::*;
();

   localparam int RANDOM_ITEMS = 1650;
   localparam int IDLE_PCT     = 22;
   localparam int HOLD_CYCLES  = 60;
   localparam int DRAIN_CYCLES = 10;

   // one decoded result as the block should return it
   typedef struct {
      cp_type code_point;
      logic   end_marker;
   } point_type;

   logic clock;
   logic reset;

   u8d_req_if req_chan ();
   u8d_rsp_if rsp_chan ();

   utf8_byte_stream_decoder uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   byte_type  byte_queue[$];       // bytes waiting to be offered
   point_type expected_points[$];  // predicted results, oldest first

   // decoder state as the predictor sees it
   cp_type   model_part;
   pend_type model_pend;

   int  bytes_taken;   // bytes accepted so far
   int  hold_count;    // receiver hold-off cycles left
   bit  hold_done[2];
   int  error_count = 0;
   logic quiet;        // no idling on either side in this window

   assign quiet = (bytes_taken >= 700) && (bytes_taken < 1000);

   // ---------------------------------------------------------------------
   // Clock and reset
   // ---------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      reset <= 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
   end

   // ---------------------------------------------------------------------
   // Queue helpers
   // ---------------------------------------------------------------------
   task automatic add_byte(input byte_type b);
      byte_queue.insert(byte_queue.size(), b);
   endtask

   task automatic add_point(input point_type pt);
      expected_points.insert(expected_points.size(), pt);
   endtask

   // ---------------------------------------------------------------------
   // Predictor: one accepted byte in, at most one code point out.
   // A zero byte always ends the string, even mid-sequence. While a
   // sequence is pending every nonzero byte counts as a continuation and
   // only its low six bits are kept. Stray continuations and 11111xxx
   // leads in idle state are dropped silently.
   // ---------------------------------------------------------------------
   task automatic decode_byte(input byte_type b);
      point_type pt;
      if (b == ZERO_BYTE) begin
         model_part = '0;
         model_pend = PEND_IDLE;
         pt.code_point = '0;
         pt.end_marker = 1'b1;
         add_point(pt);
      end else if (model_pend != PEND_IDLE) begin
         model_part = (model_part << CONT_BITS) | cp_type'(b & CONT_PAY);
         model_pend = model_pend - 1'b1;
         if (model_pend == PEND_IDLE) begin
            pt.code_point = model_part;
            pt.end_marker = 1'b0;
            add_point(pt);
            model_part = '0;
         end
      end else if ((b & ASCII_MASK) == ZERO_BYTE) begin
         pt.code_point = cp_type'(b);
         pt.end_marker = 1'b0;
         add_point(pt);
      end else if ((b & LEAD2_MASK) == LEAD2_CODE) begin
         model_part = cp_type'(b & LEAD2_PAY);
         model_pend = PEND_ONE;
      end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
         model_part = cp_type'(b & LEAD3_PAY);
         model_pend = PEND_TWO;
      end else if ((b & LEAD4_MASK) == LEAD4_CODE) begin
         model_part = cp_type'(b & LEAD4_PAY);
         model_pend = PEND_THREE;
      end
      // anything else in idle state is skipped
   endtask

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   // random lead byte for a sequence owing n continuations
   function automatic byte_type lead_for(input int n);
      case (n)
         1:       lead_for = LEAD2_CODE | byte_type'($urandom_range(0, 31));
         2:       lead_for = LEAD3_CODE | byte_type'($urandom_range(0, 15));
         default: lead_for = LEAD4_CODE | byte_type'($urandom_range(0, 7));
      endcase
   endfunction

   function automatic byte_type random_cont();
      random_cont = ASCII_MASK | byte_type'($urandom_range(0, 63));
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus: directed bytes, then random traffic, mostly well-formed
   // sequences with noise and broken sequences mixed in.
   // ---------------------------------------------------------------------
   initial begin
      int planned;
      int pick;
      int n;
      int k;

      // directed part
      byte_queue = '{
         8'h00,                     // end marker from idle
         8'h7F, 8'h01,              // ASCII extremes
         8'hC2, 8'hA9,              // two-byte sequence
         8'hE2, 8'h82, 8'hAC,       // three-byte sequence
         8'hF7, 8'hBF, 8'hBF, 8'hBF,// four-byte, largest code point
         8'h80,                     // stray continuation, skipped
         8'hF8, 8'hFF,              // invalid leads, skipped
         8'hC3, 8'h41,              // ASCII byte taken as continuation
         8'hE0, 8'hFF, 8'hC0,       // lead bytes taken as continuations
         8'hF0, 8'h90, 8'h00,       // end inside a sequence
         8'hC0, 8'h80               // overlong form passes
      };

      planned = 0;
      while (planned < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 35) begin
            add_byte(byte_type'($urandom_range(1, 127)));
            planned++;
         end else if (pick < 80) begin
            n = $urandom_range(1, 3);
            add_byte(lead_for(n));
            repeat (n) add_byte(random_cont());
            planned += n + 1;
         end else if (pick < 86) begin
            add_byte(ZERO_BYTE);
            planned++;
         end else if (pick < 92) begin
            // ignored bytes: not counted
            if ($urandom_range(0, 1))
               add_byte(random_cont());
            else
               add_byte(byte_type'($urandom_range(8'hF8, 8'hFF)));
         end else begin
            // broken sequence: short, then any byte at all
            n = $urandom_range(1, 3);
            k = $urandom_range(0, n - 1);
            add_byte(lead_for(n));
            repeat (k) add_byte(byte_type'($urandom_range(1, 255)));
            add_byte(byte_type'($urandom_range(0, 255)));
            planned += k + 2;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Driver: offers the next queued byte, holds it until accepted, and
   // predicts each byte at the edge that accepts it.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid   <= 1'b0;
         req_chan.byte_in <= ZERO_BYTE;
         model_part = '0;
         model_pend = PEND_IDLE;
         bytes_taken    <= 0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            decode_byte(req_chan.byte_in);
            bytes_taken <= bytes_taken + 1;
         end
         if (!req_chan.valid || req_chan.ready) begin
            // keep offering while the receiver holds off so the block fills
            if (byte_queue.size() != 0 &&
                (quiet || hold_count > 0 || $urandom_range(0, 99) >= IDLE_PCT)) begin
               req_chan.valid   <= 1'b1;
               req_chan.byte_in <= byte_queue.pop_front();
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: checks each accepted result against the oldest prediction,
   // and drives ready with random stalls plus two long hold-offs.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      point_type pt;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         hold_count     <= 0;
         hold_done[0]   <= 1'b0;
         hold_done[1]   <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_points.size() == 0) begin
               $error("unexpected result: code_point=%0h end_marker=%0b",
                      rsp_chan.code_point, rsp_chan.end_marker);
               error_count++;
            end else begin
               pt = expected_points.pop_front();
               if (rsp_chan.code_point !== pt.code_point) begin
                  $error("code_point: expected %0h, actual %0h",
                         pt.code_point, rsp_chan.code_point);
                  error_count++;
               end
               if (rsp_chan.end_marker !== pt.end_marker) begin
                  $error("end_marker: expected %0b, actual %0b",
                         pt.end_marker, rsp_chan.end_marker);
                  error_count++;
               end
            end
         end

         if (hold_count > 0) begin
            rsp_chan.ready <= 1'b0;
            hold_count     <= hold_count - 1;
         end else if (!hold_done[0] && bytes_taken >= 400) begin
            rsp_chan.ready <= 1'b0;
            hold_count     <= HOLD_CYCLES;
            hold_done[0]   <= 1'b1;
         end else if (!hold_done[1] && bytes_taken >= 1300) begin
            rsp_chan.ready <= 1'b0;
            hold_count     <= HOLD_CYCLES;
            hold_done[1]   <= 1'b1;
         end else begin
            rsp_chan.ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
         end
      end
   end

   // ---------------------------------------------------------------------
   // End of run: all bytes accepted, all predictions consumed, then a drain
   // window to catch any extra result still in the pipeline. Polled on the
   // falling edge so the rising-edge updates have settled.
   // ---------------------------------------------------------------------
   initial begin
      @(negedge reset);
      @(negedge clock);
      while (byte_queue.size() != 0 || req_chan.valid) @(negedge clock);
      while (expected_points.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_points.size() != 0) begin
         $error("%0d predicted results never arrived", expected_points.size());
      end
      if (error_count == 0 && expected_points.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // Watchdog, far beyond the slowest correct run.
   initial begin
      #400_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
